// ===== rtl/bounded_uniform_random_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Bounded uniform random unit: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_UNIFORM_RANDOM_UNIT_DEFINES_SVH
`define BOUNDED_UNIFORM_RANDOM_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BUR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bounded uniform random unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BUR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bounded uniform random unit: next-cycle check failed");

`endif

// ===== rtl/bur_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded uniform random unit package
// Types and constants shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package bur_pkg;

  localparam int unsigned ValW   = 32;
  localparam int unsigned StateW = 64;

  // Register index, taken from the byte address at an 8-byte pitch.
  typedef enum logic [0:0] {
    REG_SEED_STATE  = 1'b0,
    REG_SEED_STREAM = 1'b1
  } reg_idx_e;

  // Source of the value loaded into the output register.
  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_LOW  = 2'd1,
    RES_DRAW = 2'd2,
    RES_MOD  = 2'd3
  } res_sel_e;

  typedef struct packed {
    logic     load_req;
    logic     div_limit;
    logic     draw;
    logic     div_mod;
    logic     load_out;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic lt;
    logic eq;
    logic full;
    logic gen_busy;
    logic div_busy;
    logic reject;
  } sts_t;

endpackage

// ===== rtl/bur_div.sv =====
// ----------------------------------------------------------------------------
// Bounded uniform random unit: remainder divider
// Restoring divider, one quotient bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module bur_div import bur_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [ValW-1:0] dividend_i,
  input  logic [ValW-1:0] divisor_i,
  output logic            busy_o,
  output logic [ValW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(ValW);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [ValW-1:0] num_q, num_d;
  logic [ValW-1:0] den_q, den_d;
  logic [ValW-1:0] rem_q, rem_d;
  logic [ValW:0]   trial;
  logic [ValW:0]   diff;

  assign trial = {rem_q, num_q[ValW-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '1;
      num_d  = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[ValW-2:0], 1'b0};
      // Keep the difference when the divisor fits into the partial remainder.
      rem_d = diff[ValW] ? trial[ValW-1:0] : diff[ValW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/bur_lcg.sv =====
// ----------------------------------------------------------------------------
// Bounded uniform random unit: generator state
// Seed registers, 64-bit LCG state and increment, and a four-step advance
// that forms the low 64 bits of the product with one 32x32 multiplier.
// ----------------------------------------------------------------------------
module bur_lcg import bur_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  reg_idx_e          cfg_reg_i,
  input  logic [StateW-1:0] cfg_wdata_i,
  input  logic              draw_i,
  output logic [StateW-1:0] state_o,
  output logic              busy_o,
  output logic [StateW-1:0] seed_state_o,
  output logic [StateW-1:0] seed_stream_o
);

  localparam logic [StateW-1:0] LcgMult = 64'h5851_F42D_4C95_7F2D;

  localparam logic [1:0] StepLow   = 2'd0;
  localparam logic [1:0] StepCrossA = 2'd1;
  localparam logic [1:0] StepCrossB = 2'd2;
  localparam logic [1:0] StepAddInc = 2'd3;

  logic [StateW-1:0] seed_state_q, seed_state_d;
  logic [StateW-1:0] seed_stream_q, seed_stream_d;
  logic [StateW-1:0] state_q, state_d;
  logic [StateW-1:0] inc_q, inc_d;
  logic [StateW-1:0] acc_q, acc_d;
  logic [1:0]        step_q, step_d;
  logic              busy_q, busy_d;
  logic [ValW-1:0]   mul_a, mul_b;
  logic [StateW-1:0] prod;

  assign mul_a = (step_q == StepCrossA) ? state_q[StateW-1:ValW] : state_q[ValW-1:0];
  assign mul_b = (step_q == StepCrossB) ? LcgMult[StateW-1:ValW] : LcgMult[ValW-1:0];
  assign prod  = mul_a * mul_b;

  always_comb begin
    seed_state_d  = seed_state_q;
    seed_stream_d = seed_stream_q;
    state_d       = state_q;
    inc_d         = inc_q;
    acc_d         = acc_q;
    step_d        = step_q;
    busy_d        = busy_q;
    if (cfg_we_i) begin
      if (cfg_reg_i == REG_SEED_STATE) begin
        seed_state_d = cfg_wdata_i;
      end else begin
        seed_stream_d = cfg_wdata_i;
      end
      // Advancing from zero yields the increment, so the first seeding step
      // collapses to a single add; the second advance runs below.
      inc_d   = {seed_stream_d[StateW-2:0], 1'b1};
      state_d = inc_d + seed_state_d;
      step_d  = StepLow;
      busy_d  = 1'b1;
    end else if (draw_i) begin
      step_d = StepLow;
      busy_d = 1'b1;
    end else if (busy_q) begin
      step_d = step_q + 1'b1;
      case (step_q)
        StepLow: begin
          acc_d = prod;
        end
        StepCrossA, StepCrossB: begin
          acc_d = {acc_q[StateW-1:ValW] + prod[ValW-1:0], acc_q[ValW-1:0]};
        end
        StepAddInc: begin
          state_d = acc_q + inc_q;
          busy_d  = 1'b0;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  // Reset leaves the seeding of zero registers half done: state = increment = 1.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_state_q  <= '0;
      seed_stream_q <= '0;
      state_q       <= StateW'(1);
      inc_q         <= StateW'(1);
      step_q        <= StepLow;
      busy_q        <= 1'b1;
    end else begin
      seed_state_q  <= seed_state_d;
      seed_stream_q <= seed_stream_d;
      state_q       <= state_d;
      inc_q         <= inc_d;
      step_q        <= step_d;
      busy_q        <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign state_o       = state_q;
  assign busy_o        = busy_q;
  assign seed_state_o  = seed_state_q;
  assign seed_stream_o = seed_stream_q;

endmodule

// ===== rtl/bur_dp.sv =====
// ----------------------------------------------------------------------------
// Bounded uniform random unit: datapath
// Request operands, range classification, output permutation, rejection
// compare and result register, around the generator and the divider.
// ----------------------------------------------------------------------------
module bur_dp import bur_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [ValW-1:0]   range_low_i,
  input  logic [ValW-1:0]   range_high_i,
  output logic [ValW-1:0]   random_value_o,
  input  logic              cfg_we_i,
  input  reg_idx_e          cfg_reg_i,
  input  logic [StateW-1:0] cfg_wdata_i,
  output logic [StateW-1:0] seed_state_o,
  output logic [StateW-1:0] seed_stream_o
);

  // XSH-RR: xorshift high bits, then rotate right by the top five bits.
  function automatic logic [ValW-1:0] pcg_output(input logic [StateW-1:0] s);
    logic [StateW-1:0] mixed;
    logic [ValW-1:0]   xs;
    logic [4:0]        rot;
    logic [2*ValW-1:0] dbl;
    mixed = s ^ (s >> 18);
    xs    = mixed[58:27];
    rot   = s[63:59];
    dbl   = {xs, xs} >> rot;
    return dbl[ValW-1:0];
  endfunction

  logic [ValW-1:0]   low_q, high_q;
  logic [ValW-1:0]   n_q;
  logic [ValW-1:0]   out_q;
  logic [ValW-1:0]   span;
  logic [ValW-1:0]   div_num;
  logic [ValW-1:0]   rem;
  logic [ValW-1:0]   res;
  logic [StateW-1:0] lcg_state;
  logic              gen_busy;
  logic              div_busy;

  bur_lcg u_lcg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_reg_i     (cfg_reg_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .draw_i        (cmd_i.draw),
    .state_o       (lcg_state),
    .busy_o        (gen_busy),
    .seed_state_o  (seed_state_o),
    .seed_stream_o (seed_stream_o)
  );

  assign div_num = cmd_i.div_limit ? '1 : n_q;

  bur_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_limit | cmd_i.div_mod),
    .dividend_i (div_num),
    .divisor_i  (span),
    .busy_o     (div_busy),
    .rem_o      (rem)
  );

  assign span = high_q - low_q + 1'b1;

  always_comb begin
    sts_o.lt       = high_q < low_q;
    sts_o.eq       = high_q == low_q;
    sts_o.full     = span == '0;
    sts_o.gen_busy = gen_busy;
    sts_o.div_busy = div_busy;
    // After the limit division the remainder r gives the limit ~r.
    sts_o.reject   = n_q >= ~rem;
  end

  always_comb begin
    case (cmd_i.res_sel)
      RES_ZERO: res = '0;
      RES_LOW:  res = low_q;
      RES_DRAW: res = n_q;
      RES_MOD:  res = low_q + rem;
      default:  res = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      low_q  <= range_low_i;
      high_q <= range_high_i;
    end
    if (cmd_i.draw) begin
      n_q <= pcg_output(lcg_state);
    end
    if (cmd_i.load_out) begin
      out_q <= res;
    end
  end

  assign random_value_o = out_q;

endmodule

// ===== rtl/bur_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bounded uniform random unit: controller
// Sequences classification, limit division, draws with rejection, the
// final modulo division and the hand-off to the output register.
// ----------------------------------------------------------------------------
module bur_ctrl import bur_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid_i,
  output logic s_tready_o,
  output logic m_tvalid_o,
  input  logic m_tready_i,
  input  logic cfg_wr_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_CLASS   = 6'b000010,
    ST_DRAW    = 6'b000100,
    ST_LIMWAIT = 6'b001000,
    ST_MODWAIT = 6'b010000,
    ST_DONE    = 6'b100000
  } state_e;

  state_e   state_q, state_d;
  res_sel_e res_sel_q, res_sel_d;
  logic     out_valid_q, out_valid_d;

  // No request is taken in the cycle a register write reseeds the generator.
  assign s_tready_o = (state_q == ST_IDLE) && !cfg_wr_i;

  always_comb begin
    state_d         = state_q;
    res_sel_d       = res_sel_q;
    cmd_o           = '0;
    cmd_o.res_sel   = res_sel_q;
    out_valid_d     = out_valid_q && !m_tready_i;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i && s_tready_o) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_CLASS;
        end
      end
      ST_CLASS: begin
        if (sts_i.lt) begin
          res_sel_d = RES_ZERO;
          state_d   = ST_DONE;
        end else if (sts_i.eq) begin
          res_sel_d = RES_LOW;
          state_d   = ST_DONE;
        end else begin
          cmd_o.div_limit = !sts_i.full;
          state_d         = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (!sts_i.gen_busy) begin
          cmd_o.draw = 1'b1;
          if (sts_i.full) begin
            res_sel_d = RES_DRAW;
            state_d   = ST_DONE;
          end else begin
            state_d = ST_LIMWAIT;
          end
        end
      end
      ST_LIMWAIT: begin
        if (!sts_i.div_busy) begin
          if (sts_i.reject) begin
            state_d = ST_DRAW;
          end else begin
            cmd_o.div_mod = 1'b1;
            state_d       = ST_MODWAIT;
          end
        end
      end
      ST_MODWAIT: begin
        if (!sts_i.div_busy) begin
          res_sel_d = RES_MOD;
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_tready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_sel_q   <= RES_ZERO;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_sel_q   <= res_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;

endmodule

// ===== rtl/bounded_uniform_random_unit.sv =====
// ----------------------------------------------------------------------------
// Bounded uniform random unit
// Returns one uniformly distributed 32-bit value per range request.
// ----------------------------------------------------------------------------
// A request names an inclusive range [range_low, range_high]; one value comes
// back per request, in order. Requests are handled one at a time. An empty
// range (high below low) returns 0 and an equal range returns the bound. The
// full 32-bit range returns one raw PCG32 output. Any other range takes two
// remainder divisions by the range size (the rejection limit, then the final
// modulo) in a bit-serial divider, with the generator draw running beside the
// first division. A rejected draw is followed by a new draw; each rejected
// draw after the first waits for the four-step state advance on the shared
// 32x32 multiplier. The controller returns to idle when the output register
// is loaded, and the next request can be accepted from there. A register
// write reseeds the generator, as does reset; a request that needs a draw
// waits for that to finish. A finished value waits in the output register
// while the next request is taken.
module bounded_uniform_random_unit import bur_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Requests.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,  // [31:0] range_low, [63:32] range_high
  // Results.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,  // [31:0] random_value
  // Register port: seed_state at 0x0, seed_stream at 0x8.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  cmd_t              cmd;
  sts_t              sts;
  logic              cfg_wr;
  reg_idx_e          cfg_reg;
  logic [StateW-1:0] seed_state;
  logic [StateW-1:0] seed_stream;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_reg = reg_idx_e'(paddr[3]);
  assign prdata  = (cfg_reg == REG_SEED_STATE) ? seed_state : seed_stream;

  bur_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cfg_wr_i   (cfg_wr),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bur_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .range_low_i    (s_axis_tdata[31:0]),
    .range_high_i   (s_axis_tdata[63:32]),
    .random_value_o (m_axis_tdata),
    .cfg_we_i       (cfg_wr),
    .cfg_reg_i      (cfg_reg),
    .cfg_wdata_i    (pwdata),
    .seed_state_o   (seed_state),
    .seed_stream_o  (seed_stream)
  );

endmodule

// ===== rtl/bur_chk.sv =====
// ----------------------------------------------------------------------------
// Bounded uniform random unit: port checker
// Watches the top-level ports for ordering and hold rules of this block.
// ----------------------------------------------------------------------------
`include "bounded_uniform_random_unit_defines.svh"

module bur_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite
);

  // A register write and a request are never taken in the same cycle.
  `BUR_ASSERT_SAME(a_no_req_on_write, clk_i, rst_ni, psel && penable && pwrite, !s_axis_tready)

  // Requests are handled one at a time: ready drops after each transaction.
  `BUR_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // A waiting result stays valid and unchanged until it is taken.
  `BUR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind bounded_uniform_random_unit bur_chk u_bur_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounded uniform random unit testbench
// Sends range requests over the input stream and predicts every returned
// value with a PCG32 model kept in a scoreboard. The seeds are reprogrammed
// over the register port between phases, with each register read back. The
// sender works in bursts and the receiver stalls in changing patterns, once
// for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import bur_pkg::*;

  localparam int CycleLimit     = 1_000_000;
  localparam int HoldOffCycles  = 600;
  localparam int RandomPerPhase = 387;

  typedef enum int {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PERIODIC,
    READY_SPARSE
  } ready_mode_e;

  // Keeps a PCG32 generator in step with the block and queues the value
  // that each accepted range request must return.
  class range_draw_scoreboard;
    localparam bit [63:0] PcgMult = 64'd6364136223846793005;

    bit [63:0] seed_state_q;
    bit [63:0] seed_stream_q;
    bit [63:0] lcg_state;
    bit [63:0] lcg_inc;
    bit [31:0] expected_values[$];

    function new();
      seed_state_q  = '0;
      seed_stream_q = '0;
      reseed();
    endfunction

    function void advance();
      lcg_state = lcg_state * PcgMult + lcg_inc;
    endfunction

    function void reseed();
      lcg_state = '0;
      lcg_inc   = {seed_stream_q[62:0], 1'b1};
      advance();
      lcg_state = lcg_state + seed_state_q;
      advance();
    endfunction

    // XSH-RR output of the current state; the state moves on by one step.
    function bit [31:0] draw();
      bit [63:0] old_state;
      bit [31:0] xs;
      bit [4:0]  rot;
      bit [63:0] pair;
      old_state = lcg_state;
      advance();
      xs   = 32'(((old_state >> 18) ^ old_state) >> 27);
      rot  = old_state[63:59];
      pair = {xs, xs} >> rot;
      return pair[31:0];
    endfunction

    function void write_reg(input reg_idx_e idx, input bit [63:0] value);
      if (idx == REG_SEED_STATE) begin
        seed_state_q = value;
      end else begin
        seed_stream_q = value;
      end
      reseed();
    endfunction

    function void note_request(input bit [31:0] lo, input bit [31:0] hi);
      bit [31:0] span;
      bit [31:0] limit;
      bit [31:0] n;
      if (hi < lo) begin
        expected_values.push_back('0);
      end else if (hi == lo) begin
        expected_values.push_back(lo);
      end else begin
        span = hi - lo + 1;
        // The whole 32-bit range wraps the size to zero: one raw draw.
        if (span == 0) begin
          expected_values.push_back(draw());
        end else begin
          limit = 32'hFFFF_FFFF - (32'hFFFF_FFFF % span);
          do begin
            n = draw();
          end while (n >= limit);
          expected_values.push_back(lo + n % span);
        end
      end
    endfunction

    function bit check_value(input logic [31:0] got, output string why);
      bit [31:0] want;
      why = "";
      if (expected_values.size() == 0) begin
        why = $sformatf("result 0x%08h with no request waiting", got);
        return 1'b0;
      end
      want = expected_values.pop_front();
      if (got !== want) begin
        why = $sformatf("random_value 0x%08h, predicted 0x%08h", got, want);
        return 1'b0;
      end
      return 1'b1;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // [31:0] range_low, [63:32] range_high
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] random_value
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  range_draw_scoreboard board;
  int cycle_count;
  int error_count;
  int burst_left;
  bit hold_off_req;

  bounded_uniform_random_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles", CycleLimit);
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string why);
    error_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, why);
  endtask

  task automatic apb_write(input reg_idx_e idx, input bit [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    board.write_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic apb_read(input reg_idx_e idx, output logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    value   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_seeds(input bit [63:0] state_value, input bit [63:0] stream_value);
    logic [63:0] readback;
    apb_read(REG_SEED_STATE, readback);
    if (readback !== state_value) begin
      report_mismatch($sformatf("seed_state reads 0x%016h, wrote 0x%016h",
                                readback, state_value));
    end
    apb_read(REG_SEED_STREAM, readback);
    if (readback !== stream_value) begin
      report_mismatch($sformatf("seed_stream reads 0x%016h, wrote 0x%016h",
                                readback, stream_value));
    end
  endtask

  task automatic load_seeds(input bit [63:0] state_value, input bit [63:0] stream_value);
    // Every write reseeds, so the order of the two writes is varied.
    if ($urandom_range(0, 1) == 1) begin
      apb_write(REG_SEED_STATE, state_value);
      apb_write(REG_SEED_STREAM, stream_value);
    end else begin
      apb_write(REG_SEED_STREAM, stream_value);
      apb_write(REG_SEED_STATE, state_value);
    end
    check_seeds(state_value, stream_value);
  endtask

  task automatic send_request(input bit [31:0] lo, input bit [31:0] hi);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hi, lo};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    board.note_request(lo, hi);
    burst_left--;
  endtask

  task automatic wait_drained();
    while (board.expected_values.size() != 0) @(posedge clk_i);
  endtask

  // Mostly ordinary ranges with random content; a share of the requests hits
  // the empty, single-value, full and rejection-heavy cases.
  task automatic pick_range(output bit [31:0] lo, output bit [31:0] hi);
    int kind;
    kind = $urandom_range(0, 99);
    lo = $urandom;
    if (kind < 45) begin
      hi = lo + $urandom_range(1, 1000);
    end else if (kind < 60) begin
      hi = $urandom;
    end else if (kind < 70) begin
      // Sizes just above half the range reject nearly every second draw.
      lo = $urandom_range(0, 32'h7FFF_FFFF);
      hi = lo + 32'h8000_0000 + $urandom_range(0, 255);
    end else if (kind < 76) begin
      hi = lo;
    end else if (kind < 80) begin
      lo = '0;
      hi = 32'hFFFF_FFFF;
    end else if (kind < 86) begin
      if (lo == 0) lo = 32'd1;
      hi = $urandom_range(0, lo - 1);
    end else begin
      hi = lo + ((32'd1 << $urandom_range(1, 31)) - 1);
    end
  endtask

  initial begin
    bit [63:0] directed_reqs [19];
    bit [31:0] req_low;
    bit [31:0] req_high;
    bit [63:0] state_value;
    bit [63:0] stream_value;

    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst_ni        <= 1'b0;
    cycle_count   = 0;
    error_count   = 0;
    burst_left    = 0;
    hold_off_req  = 1'b0;
    board = new();

    // Entries are {range_high, range_low}.
    directed_reqs = '{
      {32'h0000_0000, 32'h0000_0000}, {32'hFFFF_FFFF, 32'hFFFF_FFFF},
      {32'h0000_0000, 32'hFFFF_FFFF}, {32'h0000_0000, 32'h0000_0001},
      {32'h7FFF_FFFF, 32'h8000_0000}, {32'hFFFF_FFFF, 32'h0000_0000},
      {32'h0000_0001, 32'h0000_0000}, {32'hFFFF_FFFF, 32'hFFFF_FFFE},
      {32'h8000_0000, 32'h0000_0000}, {32'hFFFF_FFFF, 32'h7FFF_FFFF},
      {32'hFFFF_FFFE, 32'h0000_0000}, {32'hFFFF_FFFF, 32'h0000_0001},
      {32'h0000_0007, 32'h0000_0005}, {32'h0000_0000, 32'h0000_0000},
      {32'h1234_56DB, 32'h1234_5678}, {32'h5555_5555, 32'hAAAA_AAAA},
      {32'hAAAA_AAAA, 32'h5555_5555}, {32'hFFFF_FFFF, 32'h0000_0000},
      {32'h0000_0002, 32'h0000_0000}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_seeds(64'd0, 64'd0);

    foreach (directed_reqs[i]) begin
      send_request(directed_reqs[i][31:0], directed_reqs[i][63:32]);
    end

    for (int phase = 0; phase < 5; phase++) begin
      s_axis_tvalid <= 1'b0;
      wait_drained();
      repeat (8) @(posedge clk_i);
      case (phase)
        0: begin
          state_value  = '1;
          stream_value = '1;
        end
        1: begin
          state_value  = '0;
          stream_value = '1;
        end
        2: begin
          state_value  = '1;
          stream_value = '0;
        end
        3: begin
          state_value  = {$urandom, $urandom};
          stream_value = {$urandom, $urandom};
        end
        default: begin
          state_value  = '0;
          stream_value = '0;
        end
      endcase
      load_seeds(state_value, stream_value);
      burst_left = 0;
      // Long output stall while requests keep coming, so the input backs up.
      if (phase == 1) hold_off_req = 1'b1;
      repeat (RandomPerPhase) begin
        pick_range(req_low, req_high);
        send_request(req_low, req_high);
      end
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result side: checks each transaction and shapes the ready pattern.
  initial begin
    ready_mode_e ready_mode;
    int          mode_cycles;
    int          hold_cycles;
    string       why;
    ready_mode    = READY_ALWAYS;
    mode_cycles   = 0;
    hold_cycles   = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (!board.check_value(m_axis_tdata, why)) report_mismatch(why);
      end
      if (hold_off_req) begin
        hold_cycles  = HoldOffCycles;
        hold_off_req = 1'b0;
      end
      if (mode_cycles == 0) begin
        ready_mode  = ready_mode_e'($urandom_range(0, 3));
        mode_cycles = $urandom_range(64, 256);
      end
      mode_cycles--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        case (ready_mode)
          READY_ALWAYS:   m_axis_tready <= 1'b1;
          READY_RANDOM:   m_axis_tready <= 1'($urandom_range(0, 1));
          READY_PERIODIC: m_axis_tready <= (cycle_count % 3 != 0);
          default:        m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bur_pkg.sv
rtl/bur_div.sv
rtl/bur_lcg.sv
rtl/bur_dp.sv
rtl/bur_ctrl.sv
rtl/bounded_uniform_random_unit.sv
rtl/bur_chk.sv
tb/testbench.sv
